>>> src/lmdd_pkg.sv
`default_nettype none
package lmdd_pkg;

    localparam logic [1:0] KIND_LOCK    = 2'd0;
    localparam logic [1:0] KIND_TRYLOCK = 2'd1;
    localparam logic [1:0] KIND_UNLOCK  = 2'd2;

    localparam logic [2:0] ST_GRANTED   = 3'd0;
    localparam logic [2:0] ST_QUEUED    = 3'd1;
    localparam logic [2:0] ST_TRY_FAIL  = 3'd2;
    localparam logic [2:0] ST_FREED     = 3'd3;
    localparam logic [2:0] ST_HANDOFF   = 3'd4;
    localparam logic [2:0] ST_NOT_OWNER = 3'd5;
    localparam logic [2:0] ST_CYCLE     = 3'd6;

    typedef struct packed {
        logic [1:0] kind;
        logic [3:0] lock_index;
        logic [3:0] requester;
    } req_t;

    typedef struct packed {
        logic [2:0] status;
        logic [3:0] woken_pid;
        logic       deadlock;
        logic [3:0] cycle_pid;
        logic       last;
    } rsp_t;

endpackage
`default_nettype wire

>>> src/lmdd_front.sv
`default_nettype none
module lmdd_front
    import lmdd_pkg::*;
#(
    parameter int NUM_PROCS = 16,
    parameter int NUM_LOCKS = 16
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_stall,
    input  wire req_t in_item,
    output logic      q_valid,
    input  wire logic q_stall,
    output req_t      q_item
);

    // Two-entry queue; out-of-range and kind three items are dropped here.
    req_t       mem_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;
    logic       keep, push, pop;

    assign keep = (in_item.kind != 2'd3)
               && (32'(in_item.lock_index) < 32'(NUM_LOCKS))
               && (32'(in_item.requester) < 32'(NUM_PROCS));
    assign in_stall = (count_reg == 2'd2);
    assign push = in_valid && !in_stall && keep;
    assign q_valid = (count_reg != 2'd0);
    assign q_item = mem_reg[rd_ptr_reg];
    assign pop = q_valid && !q_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_reg + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= in_item;
    end

endmodule
`default_nettype wire

>>> src/lmdd_back.sv
`default_nettype none
module lmdd_back
    import lmdd_pkg::*;
#(
    parameter int NUM_PROCS = 16,
    parameter int NUM_LOCKS = 16
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic q_valid,
    output logic      q_stall,
    input  wire req_t q_item,
    output logic      out_valid,
    input  wire logic out_stall,
    output rsp_t      out_item
);

    localparam int PW = 4;
    localparam int LW = 4;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_WALK = 5'b00010,
        S_EMIT = 5'b00100,
        S_REQ  = 5'b01000,
        S_WAIT = 5'b10000
    } state_t;

    state_t state_reg;

    logic [NUM_LOCKS-1:0] held_reg;
    logic [PW-1:0]        owner_reg [NUM_LOCKS];
    logic [NUM_LOCKS-1:0] qv_reg;
    logic [PW-1:0]        head_reg  [NUM_LOCKS];
    logic [PW-1:0]        tail_reg  [NUM_LOCKS];
    logic [PW-1:0]        nextw_reg [NUM_PROCS];
    logic [NUM_PROCS-1:0] wv_reg;
    logic [LW-1:0]        won_reg   [NUM_PROCS];
    logic [NUM_PROCS-1:0] seen_reg;

    logic [PW-1:0] chain_reg [NUM_PROCS];
    logic [PW:0]   count_reg;
    logic [PW:0]   idx_reg;
    logic [PW-1:0] cur_reg, req_reg;
    logic          req_first_reg;

    logic          ov_reg;
    rsp_t          o_reg;
    logic          o_free;

    assign out_valid = ov_reg;
    assign out_item  = o_reg;
    assign o_free    = !ov_reg || !out_stall;
    assign q_stall   = !(state_reg == S_IDLE && o_free);

    logic [LW-1:0] lk;
    logic [PW-1:0] rq, w, wl_own;
    logic [LW-1:0] wl;
    logic          enq, emit;
    assign lk = q_item.lock_index[LW-1:0];
    assign rq = q_item.requester[PW-1:0];
    assign w  = head_reg[lk];
    assign wl = won_reg[cur_reg];
    assign wl_own = owner_reg[wl];

    // A lock on a held lock by a process that does not wait yet is queued.
    assign enq  = (q_item.kind == KIND_LOCK) && !wv_reg[rq] && held_reg[lk];
    // The output register loads a new result in this cycle.
    assign emit = o_free && ((state_reg == S_IDLE && q_valid && !enq)
                             || (state_reg inside {S_WAIT, S_REQ, S_EMIT}));

    function automatic rsp_t mk(logic [2:0] st, logic [3:0] wk, logic dl,
                                logic [3:0] cp, logic lst);
        rsp_t r;
        r.status = st; r.woken_pid = wk; r.deadlock = dl;
        r.cycle_pid = cp; r.last = lst;
        return r;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            held_reg  <= '0;
            qv_reg    <= '0;
            wv_reg    <= '0;
            seen_reg  <= '0;
            ov_reg    <= 1'b0;
            count_reg <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            ov_reg <= emit || (ov_reg && out_stall);
            case (state_reg)
                S_IDLE:
                begin
                    if (q_valid && o_free)
                    begin
                        if (q_item.kind == KIND_TRYLOCK)
                        begin
                            if (held_reg[lk])
                                o_reg <= mk(ST_TRY_FAIL, 4'd0, 1'b0, 4'd0, 1'b1);
                            else
                            begin
                                held_reg[lk]  <= 1'b1;
                                owner_reg[lk] <= rq;
                                o_reg <= mk(ST_GRANTED, 4'd0, 1'b0, 4'd0, 1'b1);
                            end
                        end
                        else if (q_item.kind == KIND_UNLOCK)
                        begin
                            if (!held_reg[lk] || owner_reg[lk] != rq)
                                o_reg <= mk(ST_NOT_OWNER, 4'd0, 1'b0, 4'd0, 1'b1);
                            else if (!qv_reg[lk])
                            begin
                                held_reg[lk] <= 1'b0;
                                o_reg <= mk(ST_FREED, 4'd0, 1'b0, 4'd0, 1'b1);
                            end
                            else
                            begin
                                if (tail_reg[lk] == w)
                                    qv_reg[lk] <= 1'b0;
                                else
                                    head_reg[lk] <= nextw_reg[w];
                                owner_reg[lk] <= w;
                                wv_reg[w] <= 1'b0;
                                o_reg <= mk(ST_HANDOFF, 4'(w), 1'b0, 4'd0, 1'b1);
                            end
                        end
                        else if (wv_reg[rq])
                            o_reg <= mk(ST_TRY_FAIL, 4'd0, 1'b0, 4'd0, 1'b1);
                        else if (!held_reg[lk])
                        begin
                            held_reg[lk]  <= 1'b1;
                            owner_reg[lk] <= rq;
                            o_reg <= mk(ST_GRANTED, 4'd0, 1'b0, 4'd0, 1'b1);
                        end
                        else
                        begin
                            // Queue at the tail, then walk the owner chain.
                            if (qv_reg[lk])
                                nextw_reg[tail_reg[lk]] <= rq;
                            else
                                head_reg[lk] <= rq;
                            qv_reg[lk]   <= 1'b1;
                            tail_reg[lk] <= rq;
                            wv_reg[rq]   <= 1'b1;
                            won_reg[rq]  <= lk;
                            req_reg   <= rq;
                            cur_reg   <= rq;
                            seen_reg  <= '0;
                            count_reg <= '0;
                            state_reg <= S_WALK;
                        end
                    end
                end
                S_WALK:
                begin
                    // One hop per cycle.
                    if (!wv_reg[cur_reg] || !held_reg[wl] || seen_reg[wl_own])
                        state_reg <= S_WAIT;
                    else if (wl_own == req_reg)
                    begin
                        req_first_reg <= (count_reg == '0)
                            || (req_reg < chain_reg[count_reg[PW-1:0] - 1'b1]);
                        state_reg <= S_REQ;
                    end
                    else
                    begin
                        seen_reg[wl_own] <= 1'b1;
                        chain_reg[count_reg[PW-1:0]] <= wl_own;
                        count_reg <= count_reg + 1'b1;
                        cur_reg   <= wl_own;
                    end
                end
                S_WAIT:
                begin
                    if (o_free)
                    begin
                        o_reg <= mk(ST_QUEUED, 4'd0, 1'b0, 4'd0, 1'b1);
                        state_reg <= S_IDLE;
                    end
                end
                S_REQ:
                begin
                    if (o_free)
                    begin
                        o_reg   <= mk(ST_QUEUED, 4'd0, 1'b1, 4'd0, 1'b0);
                        idx_reg <= '0;
                        state_reg <= S_EMIT;
                    end
                end
                S_EMIT:
                begin
                    // Emits count+1 cycle entries, requester placed first or last.
                    if (o_free)
                    begin
                        if (req_first_reg)
                        begin
                            if (idx_reg == '0)
                                o_reg <= mk(ST_CYCLE, 4'd0, 1'b1, 4'(req_reg),
                                            count_reg == '0);
                            else
                                o_reg <= mk(ST_CYCLE, 4'd0, 1'b1,
                                            4'(chain_reg[idx_reg[PW-1:0] - 1'b1]),
                                            idx_reg == count_reg);
                        end
                        else
                        begin
                            if (idx_reg == count_reg)
                                o_reg <= mk(ST_CYCLE, 4'd0, 1'b1, 4'(req_reg), 1'b1);
                            else
                                o_reg <= mk(ST_CYCLE, 4'd0, 1'b1,
                                            4'(chain_reg[idx_reg[PW-1:0]]), 1'b0);
                        end
                        idx_reg <= idx_reg + 1'b1;
                        if (idx_reg == count_reg)
                            state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

>>> src/lock_manager_deadlock_detect.sv
`default_nettype none
// Channel | Direction | Handshake          | Payload
// in      | input     | in_valid/in_stall  | req_t (kind, lock_index, requester)
// out     | output    | out_valid/out_stall| rsp_t (status, woken_pid, deadlock,
//         |           |                    |        cycle_pid, last)
// An item is registered in the front queue; trylock, unlock and granted or
// refused locks then have their result registered at the back end's output.
// A queued lock walks the owner chain one hop a cycle, then emits its queued
// result and up to NUM_PROCS cycle entries, one a cycle while out_stall is low.
// Reset is asynchronous and clears the held, queue and wait flags at once.
// A two-item queue decouples the input from the back end, so a stalled output
// stops the back end while the front still takes items until both entries fill.
module lock_manager_deadlock_detect
    import lmdd_pkg::*;
#(
    parameter int NUM_PROCS = 16,
    parameter int NUM_LOCKS = 16
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_stall,
    input  wire req_t in_item,
    output logic      out_valid,
    input  wire logic out_stall,
    output rsp_t      out_item
);

    logic q_valid, q_stall;
    req_t q_item;

    // The front filters and buffers items.
    lmdd_front #(.NUM_PROCS(NUM_PROCS), .NUM_LOCKS(NUM_LOCKS)) u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
        .q_valid(q_valid), .q_stall(q_stall), .q_item(q_item)
    );

    // The back end owns all lock state and produces the results.
    lmdd_back #(.NUM_PROCS(NUM_PROCS), .NUM_LOCKS(NUM_LOCKS)) u_back (
        .clk(clk), .rst_n(rst_n),
        .q_valid(q_valid), .q_stall(q_stall), .q_item(q_item),
        .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
    );

`ifndef SYNTHESIS
    // A cycle entry always carries the deadlock flag.
    a_cycle_dl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.status == ST_CYCLE |-> out_item.deadlock)
        else $error("cycle entry without deadlock flag");
    // Only handoff results name a woken pid.
    a_woken: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.status != ST_HANDOFF |-> out_item.woken_pid == 4'd0)
        else $error("woken pid outside handoff");
    // A deadlocked queued result is never the last one.
    a_dl_more: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.status == ST_QUEUED && out_item.deadlock
        |-> !out_item.last)
        else $error("deadlock report without cycle entries");
`endif

endmodule
`default_nettype wire

>>> tb/sv/tb_top.sv
`timescale 1ns / 100ps
`default_nettype none

module tb_top;
    import lmdd_pkg::*;

    localparam int NPROC = 16;
    localparam int NLOCK = 16;
    localparam logic [4:0] NONE = 5'h1F;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    req_t in_item = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    rsp_t out_item;

    always #5 clk = ~clk;

    lock_manager_deadlock_detect uut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .in_item(in_item),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_item(out_item)
    );

    // Shadow copy of the lock table, queues and wait marks.
    logic       held_q   [NLOCK];
    logic [4:0] owner_q  [NLOCK];
    logic [4:0] head_q   [NLOCK];
    logic [4:0] tail_q   [NLOCK];
    logic [4:0] next_q   [NPROC];
    logic [4:0] waits_on [NPROC];

    // Responses still owed by the block, oldest first.
    rsp_t pending_rsp[$];
    int   mismatches = 0;

    // Idle percentages for the sender and the receiver.
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    function automatic rsp_t mk(logic [2:0] st, logic [3:0] wk, logic dl,
                                logic [3:0] cp, logic lst);
        rsp_t r;
        r.status    = st;
        r.woken_pid = wk;
        r.deadlock  = dl;
        r.cycle_pid = cp;
        r.last      = lst;
        return r;
    endfunction

    task automatic clear_lock_table();
        for (int i = 0; i < NLOCK; i++)
        begin
            held_q[i]  = 1'b0;
            owner_q[i] = NONE;
            head_q[i]  = NONE;
            tail_q[i]  = NONE;
        end
        for (int i = 0; i < NPROC; i++)
        begin
            next_q[i]   = 5'd0;
            waits_on[i] = NONE;
        end
    endtask

    // Applies one request to the shadow state and queues its responses.
    task automatic predict_lock_request(req_t rq);
        logic [4:0] lk;
        logic [4:0] pid;
        logic [4:0] w;
        logic [4:0] p;
        logic [4:0] o;
        logic [4:0] chain[$];
        logic [15:0] seen;
        logic cyc;
        lk  = {1'b0, rq.lock_index};
        pid = {1'b0, rq.requester};
        if (rq.kind == 2'd3)
            return;
        if (rq.kind == KIND_TRYLOCK)
        begin
            if (held_q[lk])
                pending_rsp.push_back(mk(ST_TRY_FAIL, 4'd0, 1'b0, 4'd0, 1'b1));
            else
            begin
                held_q[lk]  = 1'b1;
                owner_q[lk] = pid;
                pending_rsp.push_back(mk(ST_GRANTED, 4'd0, 1'b0, 4'd0, 1'b1));
            end
            return;
        end
        if (rq.kind == KIND_UNLOCK)
        begin
            if (!held_q[lk] || owner_q[lk] != pid)
            begin
                pending_rsp.push_back(mk(ST_NOT_OWNER, 4'd0, 1'b0, 4'd0, 1'b1));
                return;
            end
            w = head_q[lk];
            if (w == NONE)
            begin
                held_q[lk]  = 1'b0;
                owner_q[lk] = NONE;
                pending_rsp.push_back(mk(ST_FREED, 4'd0, 1'b0, 4'd0, 1'b1));
                return;
            end
            if (tail_q[lk] == w)
            begin
                head_q[lk] = NONE;
                tail_q[lk] = NONE;
            end
            else
                head_q[lk] = next_q[w];
            owner_q[lk] = w;
            waits_on[w] = NONE;
            pending_rsp.push_back(mk(ST_HANDOFF, w[3:0], 1'b0, 4'd0, 1'b1));
            return;
        end
        // A process that already waits may not queue a second time.
        if (waits_on[pid] != NONE)
        begin
            pending_rsp.push_back(mk(ST_TRY_FAIL, 4'd0, 1'b0, 4'd0, 1'b1));
            return;
        end
        if (!held_q[lk])
        begin
            held_q[lk]  = 1'b1;
            owner_q[lk] = pid;
            pending_rsp.push_back(mk(ST_GRANTED, 4'd0, 1'b0, 4'd0, 1'b1));
            return;
        end
        next_q[pid] = NONE;
        if (tail_q[lk] != NONE)
            next_q[tail_q[lk]] = pid;
        else
            head_q[lk] = pid;
        tail_q[lk]    = pid;
        waits_on[pid] = lk;
        // Follow the owner chain; a repeat visit means some other cycle.
        seen = '0;
        cyc  = 1'b0;
        p    = pid;
        forever
        begin
            if (waits_on[p] == NONE)
                break;
            o = owner_q[waits_on[p]];
            if (o == NONE)
                break;
            if (o == pid)
            begin
                cyc = 1'b1;
                break;
            end
            if (seen[o])
                break;
            seen[o] = 1'b1;
            chain.push_back(o);
            p = o;
        end
        pending_rsp.push_back(mk(ST_QUEUED, 4'd0, cyc, 4'd0, !cyc));
        if (!cyc)
            return;
        if (chain.size() == 0 || pid < chain[chain.size() - 1])
        begin
            pending_rsp.push_back(mk(ST_CYCLE, 4'd0, 1'b1, pid[3:0],
                                     chain.size() == 0));
            foreach (chain[i])
                pending_rsp.push_back(mk(ST_CYCLE, 4'd0, 1'b1, chain[i][3:0],
                                         i == chain.size() - 1));
        end
        else
        begin
            foreach (chain[i])
                pending_rsp.push_back(mk(ST_CYCLE, 4'd0, 1'b1, chain[i][3:0], 1'b0));
            pending_rsp.push_back(mk(ST_CYCLE, 4'd0, 1'b1, pid[3:0], 1'b1));
        end
    endtask

    // Sends one item; valid stays high across back-to-back items.
    task automatic send_item(logic [1:0] k, logic [3:0] lk, logic [3:0] pid);
        req_t rq;
        rq.kind       = k;
        rq.lock_index = lk;
        rq.requester  = pid;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= rq;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_lock_request(rq);
        @(negedge clk);
    endtask

    // Every rising edge: check an accepted response against the oldest one owed.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_rsp.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected response %p", out_item);
            end
            else
            begin
                if (out_item !== pending_rsp[0])
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("response mismatch: expected %p, got %p",
                                 pending_rsp[0], out_item);
                end
                void'(pending_rsp.pop_front());
            end
        end
    end

    // Receiver stall, redrawn at each falling edge.
    always @(negedge clk)
        out_stall <= ($urandom_range(99) < recv_idle_pct);

    // Drops valid, then waits until every owed response has come.
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_rsp.size() != 0)
            @(negedge clk);
    endtask

    // Directed cases: extremes, every kind, handoff, self wait and a real cycle.
    task automatic test_directed();
        send_item(KIND_UNLOCK, 4'd0, 4'd0);     // unlock of a free lock
        send_item(KIND_LOCK, 4'd15, 4'd15);
        send_item(KIND_TRYLOCK, 4'd15, 4'd0);   // try on a held lock fails
        send_item(KIND_LOCK, 4'd15, 4'd15);     // self wait, a cycle of one
        send_item(KIND_LOCK, 4'd3, 4'd15);      // waiting process refused
        send_item(2'd3, 4'd5, 4'd5);            // unused kind, no response
        send_item(KIND_UNLOCK, 4'd15, 4'd3);    // not the owner
        send_item(KIND_UNLOCK, 4'd15, 4'd15);   // handed to itself
        send_item(KIND_UNLOCK, 4'd15, 4'd15);   // freed
        send_item(KIND_TRYLOCK, 4'd0, 4'd10);
        send_item(KIND_TRYLOCK, 4'd1, 4'd2);
        send_item(KIND_LOCK, 4'd1, 4'd10);      // 10 waits on 2
        send_item(KIND_LOCK, 4'd0, 4'd2);       // 2 closes the cycle 2 -> 10 -> 2
        send_item(KIND_LOCK, 4'd1, 4'd7);       // queues behind 10
        send_item(KIND_UNLOCK, 4'd1, 4'd2);     // hands off to 10
        send_item(KIND_UNLOCK, 4'd1, 4'd10);    // hands off to 7
        send_item(KIND_UNLOCK, 4'd0, 4'd10);    // hands off to 2
        send_item(KIND_UNLOCK, 4'd0, 4'd2);
        send_item(KIND_UNLOCK, 4'd1, 4'd7);
        wait_drained();
    endtask

    // Random traffic over a few locks and pids so queues and cycles form often.
    task automatic test_random(int count);
        logic [1:0] k;
        for (int n = 0; n < count; n++)
        begin
            if (n == count / 2)
                wait_drained();          // let the block run dry once
            if ($urandom_range(19) == 0)
                send_item(2'($urandom_range(3)), 4'($urandom_range(15)),
                          4'($urandom_range(15)));
            else
            begin
                k = ($urandom_range(9) < 5) ? KIND_LOCK :
                    (($urandom_range(1) != 0) ? KIND_UNLOCK : KIND_TRYLOCK);
                send_item(k, 4'($urandom_range(5)), 4'($urandom_range(5)));
            end
        end
        wait_drained();
    endtask

    initial
    begin
        clear_lock_table();
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        send_idle_pct = 25;
        recv_idle_pct = 70;
        test_directed();
        test_random(170);
        send_idle_pct = 70;
        recv_idle_pct = 25;
        test_random(170);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(170);
        repeat (50) @(negedge clk);
        if (mismatches == 0 && pending_rsp.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("== FAIL ==");
        $finish;
    end

endmodule

`default_nettype wire
